@@ sv/mldc_pkg.sv @@
// Types and constants shared by the motion LED dimmer controller.
`default_nettype none

package mldc_pkg;

   // Lamp modes as shown on the result channel
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_FADE_IN  = 3'd1,
      MODE_ON       = 3'd2,
      MODE_FADE_OUT = 3'd3,
      MODE_BLINK    = 3'd4
   } mode_type;

   // Item kinds carried on req_tuser
   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_RESTORE = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_BRIGHTNESS_STEP   = 3'd0;
   localparam logic [2:0] CSR_ON_TIME_STEP      = 3'd1;
   localparam logic [2:0] CSR_MAX_ON_TIME       = 3'd2;
   localparam logic [2:0] CSR_MIN_ON_TIME       = 3'd3;
   localparam logic [2:0] CSR_FADE_DIVISOR      = 3'd4;
   localparam logic [2:0] CSR_INTERVAL_PERIOD   = 3'd5;
   localparam logic [2:0] CSR_BLINK_HALF_PERIOD = 3'd6;

   // Configuration reset values
   localparam logic [7:0]  RST_BRIGHTNESS_STEP   = 8'd25;
   localparam logic [7:0]  RST_ON_TIME_STEP      = 8'd3;
   localparam logic [7:0]  RST_MAX_ON_TIME       = 8'd60;
   localparam logic [7:0]  RST_MIN_ON_TIME       = 8'd1;
   localparam logic [15:0] RST_FADE_DIVISOR      = 16'd55;
   localparam logic [15:0] RST_INTERVAL_PERIOD   = 16'd46870;
   localparam logic [15:0] RST_BLINK_HALF_PERIOD = 16'd937;

   // Duty and brightness limits
   localparam logic [7:0] DUTY_FULL = 8'd255;
   localparam logic [7:0] DUTY_OFF  = 8'd0;

   // Last of the four blink phases
   localparam logic [1:0] BLINK_LAST_PHASE = 2'd3;

endpackage : mldc_pkg

`default_nettype wire

@@ sv/motion_led_dimmer_controller_top.sv @@
// Top level of the motion LED dimmer controller: settings, lamp sequencing and result register.
`default_nettype none

// One request item is one PWM tick (or a restore of stored settings) and gives exactly one
// response item. All the work for an item is done in a single pass of counter and compare
// logic feeding the response register, so an item is taken in every cycle: req_tready stays
// high while the response register is empty or its item is being taken in the same cycle.
// rsp_tvalid rises in the cycle after acceptance. Configuration writes are taken at once
// (csr_ready is always high) and should only be made while no item is in flight.
module motion_led_dimmer_controller_top (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   // tuser: req_type
   input  wire         req_tuser,
   // tdata, low bit up: motion, time_button_level, bright_button_level,
   // stored_brightness[7:0], stored_on_time[7:0], 5 zero bits
   input  wire  [23:0] req_tdata,
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // tdata, low bit up: led_duty[7:0], save_brightness, save_on_time,
   // cur_brightness[7:0], cur_on_time[7:0], lamp_mode[2:0], 3 zero bits
   output logic [31:0] rsp_tdata,
   // configuration write channel
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_data
);

   import mldc_pkg::*;

   // configuration registers
   logic [7:0]  brightness_step_ff, on_time_step_ff, max_on_time_ff, min_on_time_ff;
   logic [15:0] fade_divisor_ff, interval_period_ff, blink_half_period_ff;

   // lamp state
   mode_type    mode_ff, mode_in;
   logic        lit_ff, lit_in;
   logic [7:0]  brightness_ff, brightness_in;
   logic [7:0]  on_time_ff, on_time_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  interval_ff, interval_in;
   logic [15:0] prescale_ff, prescale_in;
   logic [7:0]  level_ff, level_in;
   logic [1:0]  phase_ff, phase_in;
   logic        pending_ff, pending_in;
   logic        prev_time_ff, prev_time_in;
   logic        prev_bright_ff, prev_bright_in;
   logic [7:0]  held_ff, held_in;

   // response register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // request fields
   logic        motion, time_level, bright_level;
   logic [7:0]  stored_brightness, stored_on_time;
   logic        accept;

   // per-item working values
   logic        save_b, save_t;
   logic [16:0] prescale_next;
   logic        fade_done, blink_done;
   logic [7:0]  duty;

   assign motion            = req_tdata[0];
   assign time_level        = req_tdata[1];
   assign bright_level      = req_tdata[2];
   assign stored_brightness = req_tdata[10:3];
   assign stored_on_time    = req_tdata[18:11];

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // prescaler end tests; a limit of zero acts as one
   assign prescale_next = {1'b0, prescale_ff} + 17'd1;
   assign fade_done     = prescale_next >= {1'b0, fade_divisor_ff};
   assign blink_done    = prescale_next >= {1'b0, blink_half_period_ff};

   // next state for one item
   always_comb begin
      mode_in        = mode_ff;
      lit_in         = lit_ff;
      brightness_in  = brightness_ff;
      on_time_in     = on_time_ff;
      tick_in        = tick_ff;
      interval_in    = interval_ff;
      prescale_in    = prescale_ff;
      level_in       = level_ff;
      phase_in       = phase_ff;
      pending_in     = pending_ff;
      prev_time_in   = prev_time_ff;
      prev_bright_in = prev_bright_ff;
      held_in        = held_ff;
      save_b         = 1'b0;
      save_t         = 1'b0;

      if (req_tuser == REQ_RESTORE) begin
         // load stored settings, on-time range checked
         brightness_in = stored_brightness;
         if (stored_on_time >= min_on_time_ff && stored_on_time <= max_on_time_ff) begin
            on_time_in = stored_on_time;
         end else begin
            on_time_in = min_on_time_ff;
         end
      end else begin
         // time button press: step up, wrap from max
         if (!time_level && prev_time_ff) begin
            if (on_time_ff == max_on_time_ff) begin
               on_time_in = min_on_time_ff;
            end else if ({1'b0, on_time_ff} + {1'b0, on_time_step_ff} >=
                         {1'b0, max_on_time_ff}) begin
               on_time_in = max_on_time_ff;
               pending_in = 1'b1;
            end else begin
               on_time_in = on_time_ff + on_time_step_ff;
            end
            save_t = 1'b1;
         end
         // brightness button press: step down, wrap from off
         if (!bright_level && prev_bright_ff) begin
            if (brightness_ff == DUTY_OFF) begin
               brightness_in = DUTY_FULL;
            end else if (brightness_ff <= brightness_step_ff) begin
               brightness_in = DUTY_OFF;
            end else begin
               brightness_in = brightness_ff - brightness_step_ff;
            end
            save_b = 1'b1;
         end
         prev_time_in   = time_level;
         prev_bright_in = bright_level;

         // interval timer, saturating at the on-time
         if (tick_ff >= interval_period_ff) begin
            tick_in = 16'd0;
            if (interval_ff >= on_time_in) begin
               interval_in = on_time_in;
            end else begin
               interval_in = interval_ff + 8'd1;
            end
         end else begin
            tick_in = tick_ff + 16'd1;
         end

         case (mode_ff)
            MODE_FADE_IN, MODE_FADE_OUT: begin
               prescale_in = fade_done ? 16'd0 : prescale_next[15:0];
               if (fade_done && level_ff != DUTY_FULL) begin
                  level_in = level_ff + 8'd1;
               end
               if (level_in >= brightness_in) begin
                  if (mode_ff == MODE_FADE_IN) begin
                     mode_in = MODE_ON;
                  end else begin
                     mode_in = MODE_IDLE;
                     held_in = DUTY_OFF;
                  end
               end
            end
            MODE_BLINK: begin
               prescale_in = blink_done ? 16'd0 : prescale_next[15:0];
               if (blink_done) begin
                  if (phase_ff >= BLINK_LAST_PHASE) begin
                     phase_in   = 2'd0;
                     pending_in = 1'b0;
                     held_in    = brightness_in;
                     mode_in    = lit_ff ? MODE_ON : MODE_IDLE;
                  end else begin
                     phase_in    = phase_ff + 2'd1;
                     tick_in     = 16'd0;
                     interval_in = 8'd0;
                  end
               end
            end
            default: begin
               if (!lit_ff && motion) begin
                  // motion while unlit starts the fade-in
                  lit_in      = 1'b1;
                  mode_in     = MODE_FADE_IN;
                  level_in    = 8'd0;
                  prescale_in = 16'd0;
                  tick_in     = 16'd0;
                  interval_in = 8'd0;
               end else begin
                  if (lit_ff) begin
                     mode_in = MODE_ON;
                     if (motion) begin
                        tick_in     = 16'd0;
                        interval_in = 8'd0;
                     end
                  end
                  if (lit_ff && interval_in >= on_time_in && on_time_in != max_on_time_ff) begin
                     // on-time used up: fade down
                     lit_in      = 1'b0;
                     mode_in     = MODE_FADE_OUT;
                     level_in    = 8'd0;
                     prescale_in = 16'd0;
                     tick_in     = 16'd0;
                     interval_in = 8'd0;
                  end else if (pending_in) begin
                     // confirmation blink
                     mode_in     = MODE_BLINK;
                     phase_in    = 2'd0;
                     prescale_in = 16'd0;
                     tick_in     = 16'd0;
                     interval_in = 8'd0;
                  end
               end
            end
         endcase
      end
   end

   // duty shown for the new state
   always_comb begin
      case (mode_in)
         MODE_FADE_IN:  duty = (level_in < brightness_in) ? level_in : brightness_in;
         MODE_ON:       duty = brightness_in;
         MODE_FADE_OUT: duty = (brightness_in > level_in) ? brightness_in - level_in : DUTY_OFF;
         MODE_BLINK:    duty = phase_in[0] ? brightness_in : DUTY_OFF;
         default:       duty = held_in;
      endcase
   end

   assign rsp_data_in = {3'b000, mode_in, on_time_in, brightness_in, save_t, save_b, duty};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_step_ff   <= RST_BRIGHTNESS_STEP;
         on_time_step_ff      <= RST_ON_TIME_STEP;
         max_on_time_ff       <= RST_MAX_ON_TIME;
         min_on_time_ff       <= RST_MIN_ON_TIME;
         fade_divisor_ff      <= RST_FADE_DIVISOR;
         interval_period_ff   <= RST_INTERVAL_PERIOD;
         blink_half_period_ff <= RST_BLINK_HALF_PERIOD;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BRIGHTNESS_STEP:   brightness_step_ff   <= csr_data[7:0];
            CSR_ON_TIME_STEP:      on_time_step_ff      <= csr_data[7:0];
            CSR_MAX_ON_TIME:       max_on_time_ff       <= csr_data[7:0];
            CSR_MIN_ON_TIME:       min_on_time_ff       <= csr_data[7:0];
            CSR_FADE_DIVISOR:      fade_divisor_ff      <= csr_data;
            CSR_INTERVAL_PERIOD:   interval_period_ff   <= csr_data;
            CSR_BLINK_HALF_PERIOD: blink_half_period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // lamp state, updated on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         lit_ff         <= 1'b0;
         brightness_ff  <= DUTY_FULL;
         on_time_ff     <= RST_MIN_ON_TIME;
         tick_ff        <= 16'd0;
         interval_ff    <= 8'd0;
         prescale_ff    <= 16'd0;
         level_ff       <= 8'd0;
         phase_ff       <= 2'd0;
         pending_ff     <= 1'b0;
         prev_time_ff   <= 1'b1;
         prev_bright_ff <= 1'b1;
         held_ff        <= DUTY_OFF;
      end else if (accept) begin
         mode_ff        <= mode_in;
         lit_ff         <= lit_in;
         brightness_ff  <= brightness_in;
         on_time_ff     <= on_time_in;
         tick_ff        <= tick_in;
         interval_ff    <= interval_in;
         prescale_ff    <= prescale_in;
         level_ff       <= level_in;
         phase_ff       <= phase_in;
         pending_ff     <= pending_in;
         prev_time_ff   <= prev_time_in;
         prev_bright_ff <= prev_bright_in;
         held_ff        <= held_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule : motion_led_dimmer_controller_top

`default_nettype wire

@@ dv/motion_led_dimmer_controller_top_tb.sv @@
// Self-checking testbench for the motion LED dimmer controller top level.
`timescale 1ns / 100ps

module motion_led_dimmer_controller_top_tb;
   import mldc_pkg::*;

   // One request item as the driver sees it
   typedef struct packed {
      logic       kind;
      logic       motion;
      logic       time_btn;
      logic       bright_btn;
      logic [7:0] stored_bright;
      logic [7:0] stored_time;
   } lamp_req_type;

   // One response item, split into its fields
   typedef struct packed {
      logic [7:0] duty;
      logic       save_bright;
      logic       save_time;
      logic [7:0] bright;
      logic [7:0] on_time;
      mode_type   mode;
   } lamp_res_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic        req_tuser = 1'b0;
   logic [23:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   lamp_req_type pending_items[$];
   lamp_res_type lamp_expected[$];
   lamp_req_type on_bus;
   lamp_req_type next_item;
   lamp_res_type got;
   lamp_res_type want;
   int        error_count = 0;
   int        send_idle_pct = 34;
   int        recv_idle_pct = 34;

   // Predictor settings
   logic [7:0]  set_bstep, set_tstep, set_max, set_min;
   logic [15:0] set_fade_div, set_period, set_blink_half;

   // Predictor state
   mode_type    lamp_mode;
   logic        lamp_lit;
   logic [7:0]  lamp_bright, lamp_on_time, lamp_intervals, lamp_level, lamp_hold;
   logic [15:0] lamp_ticks, lamp_prescale;
   logic [1:0]  lamp_phase;
   logic        lamp_blink_due, lamp_prev_tb, lamp_prev_bb;

   motion_led_dimmer_controller_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_intervals();
      lamp_ticks     = '0;
      lamp_intervals = '0;
   endfunction

   function automatic void start_fade(input mode_type m);
      lamp_mode     = m;
      lamp_level    = '0;
      lamp_prescale = '0;
      clear_intervals();
   endfunction

   // Prescaler step; a limit of zero behaves as one
   function automatic logic prescale_wrap(input logic [15:0] limit);
      logic [16:0] nxt;
      nxt = {1'b0, lamp_prescale} + 17'd1;
      if (nxt >= {1'b0, limit}) begin
         lamp_prescale = '0;
         return 1'b1;
      end
      lamp_prescale = nxt[15:0];
      return 1'b0;
   endfunction

   // Advance the lamp by one accepted item and give the response it should produce
   function automatic lamp_res_type lamp_step(input lamp_req_type r);
      lamp_res_type res;
      logic      wrapped;
      logic      fading_out;
      res = '0;
      if (r.kind == REQ_RESTORE) begin
         lamp_bright  = r.stored_bright;
         lamp_on_time = (r.stored_time >= set_min && r.stored_time <= set_max) ?
                        r.stored_time : set_min;
      end else begin
         // time button: falling level after released
         if (!r.time_btn && lamp_prev_tb) begin
            if (lamp_on_time == set_max) begin
               lamp_on_time = set_min;
            end else if ({1'b0, lamp_on_time} + {1'b0, set_tstep} >= {1'b0, set_max}) begin
               lamp_on_time   = set_max;
               lamp_blink_due = 1'b1;
            end else begin
               lamp_on_time = lamp_on_time + set_tstep;
            end
            res.save_time = 1'b1;
         end
         // brightness button steps down and wraps
         if (!r.bright_btn && lamp_prev_bb) begin
            if (lamp_bright == DUTY_OFF)
               lamp_bright = DUTY_FULL;
            else if (lamp_bright <= set_bstep)
               lamp_bright = DUTY_OFF;
            else
               lamp_bright = lamp_bright - set_bstep;
            res.save_bright = 1'b1;
         end
         lamp_prev_tb = r.time_btn;
         lamp_prev_bb = r.bright_btn;

         // interval timer runs in every mode
         if (lamp_ticks >= set_period) begin
            lamp_ticks = '0;
            if (lamp_intervals >= lamp_on_time)
               lamp_intervals = lamp_on_time;
            else
               lamp_intervals++;
         end else begin
            lamp_ticks++;
         end

         case (lamp_mode)
            MODE_FADE_IN, MODE_FADE_OUT: begin
               wrapped = prescale_wrap(set_fade_div);
               if (wrapped && lamp_level < DUTY_FULL)
                  lamp_level++;
               if (lamp_level >= lamp_bright) begin
                  if (lamp_mode == MODE_FADE_IN) begin
                     lamp_mode = MODE_ON;
                  end else begin
                     lamp_mode = MODE_IDLE;
                     lamp_hold = DUTY_OFF;
                  end
               end
            end
            MODE_BLINK: begin
               if (prescale_wrap(set_blink_half)) begin
                  if (lamp_phase >= BLINK_LAST_PHASE) begin
                     lamp_phase     = '0;
                     lamp_blink_due = 1'b0;
                     lamp_hold      = lamp_bright;
                     lamp_mode      = lamp_lit ? MODE_ON : MODE_IDLE;
                  end else begin
                     lamp_phase++;
                     clear_intervals();
                  end
               end
            end
            default: begin
               if (!lamp_lit && r.motion) begin
                  lamp_lit = 1'b1;
                  start_fade(MODE_FADE_IN);
               end else begin
                  fading_out = 1'b0;
                  if (lamp_lit) begin
                     lamp_mode = MODE_ON;
                     if (r.motion)
                        clear_intervals();
                     if (lamp_intervals >= lamp_on_time && lamp_on_time != set_max) begin
                        lamp_lit = 1'b0;
                        start_fade(MODE_FADE_OUT);
                        fading_out = 1'b1;
                     end
                  end
                  if (!fading_out && lamp_blink_due) begin
                     lamp_mode     = MODE_BLINK;
                     lamp_phase    = '0;
                     lamp_prescale = '0;
                     clear_intervals();
                  end
               end
            end
         endcase
      end

      case (lamp_mode)
         MODE_FADE_IN:  res.duty = (lamp_level < lamp_bright) ? lamp_level : lamp_bright;
         MODE_ON:       res.duty = lamp_bright;
         MODE_FADE_OUT: res.duty = (lamp_bright > lamp_level) ?
                                   lamp_bright - lamp_level : DUTY_OFF;
         MODE_BLINK:    res.duty = lamp_phase[0] ? lamp_bright : DUTY_OFF;
         default:       res.duty = lamp_hold;
      endcase
      res.bright  = lamp_bright;
      res.on_time = lamp_on_time;
      res.mode    = lamp_mode;
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_error(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] seen,
                              input logic [7:0] wanted);
      if (seen !== wanted)
         flag_error($sformatf("%s got %0d, expected %0d", name, seen, wanted));
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            lamp_expected.push_back(lamp_step(on_bus));
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item  = pending_items.pop_front();
            on_bus     <= next_item;
            req_tuser  <= next_item.kind;
            req_tdata  <= {5'b0, next_item.stored_time, next_item.stored_bright,
                           next_item.bright_btn, next_item.time_btn, next_item.motion};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.duty        = rsp_tdata[7:0];
            got.save_bright = rsp_tdata[8];
            got.save_time   = rsp_tdata[9];
            got.bright      = rsp_tdata[17:10];
            got.on_time     = rsp_tdata[25:18];
            got.mode        = mode_type'(rsp_tdata[28:26]);
            if (lamp_expected.size() == 0) begin
               flag_error("response item with nothing expected");
            end else begin
               want = lamp_expected.pop_front();
               check_field("led_duty", got.duty, want.duty);
               check_field("save_brightness", {7'b0, got.save_bright},
                           {7'b0, want.save_bright});
               check_field("save_on_time", {7'b0, got.save_time}, {7'b0, want.save_time});
               check_field("cur_brightness", got.bright, want.bright);
               check_field("cur_on_time", got.on_time, want.on_time);
               check_field("lamp_mode", {5'b0, got.mode}, {5'b0, want.mode});
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void queue_item(input logic kind, input logic motion,
                                      input logic tb, input logic bb,
                                      input logic [7:0] sb, input logic [7:0] st);
      lamp_req_type it;
      it.kind          = kind;
      it.motion        = motion;
      it.time_btn      = tb;
      it.bright_btn    = bb;
      it.stored_bright = sb;
      it.stored_time   = st;
      pending_items.push_back(it);
   endfunction

   task automatic csr_put(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BRIGHTNESS_STEP:   set_bstep      = value[7:0];
         CSR_ON_TIME_STEP:      set_tstep      = value[7:0];
         CSR_MAX_ON_TIME:       set_max        = value[7:0];
         CSR_MIN_ON_TIME:       set_min        = value[7:0];
         CSR_FADE_DIVISOR:      set_fade_div   = value;
         CSR_INTERVAL_PERIOD:   set_period     = value;
         CSR_BLINK_HALF_PERIOD: set_blink_half = value;
         default: ;
      endcase
   endtask

   // Write the whole register set back to back
   task automatic load_settings(input logic [7:0] bstep, input logic [7:0] tstep,
                                input logic [7:0] tmax, input logic [7:0] tmin,
                                input logic [15:0] fdiv, input logic [15:0] period,
                                input logic [15:0] bhalf);
      @(posedge clock);
      csr_put(CSR_BRIGHTNESS_STEP, {8'd0, bstep});
      csr_put(CSR_ON_TIME_STEP, {8'd0, tstep});
      csr_put(CSR_MAX_ON_TIME, {8'd0, tmax});
      csr_put(CSR_MIN_ON_TIME, {8'd0, tmin});
      csr_put(CSR_FADE_DIVISOR, fdiv);
      csr_put(CSR_INTERVAL_PERIOD, period);
      csr_put(CSR_BLINK_HALF_PERIOD, bhalf);
      csr_valid <= 1'b0;
   endtask

   // Block until every queued item has gone through and its response is in
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || lamp_expected.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // Motion bursts followed by quiet spells, short button presses scattered over them,
   // with the odd restore and a share of noise ticks
   task automatic add_random_items(input int count);
      int   motion_left, quiet_left, tb_hold, bb_hold, n;
      logic tb, bb;
      motion_left = 0;
      quiet_left  = 0;
      tb_hold     = 0;
      bb_hold     = 0;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(99) < 5) begin
            queue_item(REQ_RESTORE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)),
                       8'(($urandom_range(99) < 80) ? $urandom_range(40) : $urandom_range(255)),
                       8'(($urandom_range(99) < 70) ? $urandom_range(15) : $urandom_range(255)));
         end else if ($urandom_range(99) < 10) begin
            queue_item(REQ_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)));
         end else begin
            if (motion_left == 0 && quiet_left == 0) begin
               motion_left = $urandom_range(1, 6);
               quiet_left  = $urandom_range(3, 40);
            end
            if (tb_hold == 0 && $urandom_range(99) < 4)
               tb_hold = $urandom_range(1, 3);
            if (bb_hold == 0 && $urandom_range(99) < 3)
               bb_hold = $urandom_range(1, 3);
            tb = (tb_hold == 0);
            bb = (bb_hold == 0);
            if (tb_hold != 0) tb_hold--;
            if (bb_hold != 0) bb_hold--;
            queue_item(REQ_TICK, motion_left != 0, tb, bb,
                       8'($urandom_range(255)), 8'($urandom_range(255)));
            if (motion_left != 0)
               motion_left--;
            else
               quiet_left--;
         end
      end
   endtask

   initial begin
      int k;
      set_bstep      = RST_BRIGHTNESS_STEP;
      set_tstep      = RST_ON_TIME_STEP;
      set_max        = RST_MAX_ON_TIME;
      set_min        = RST_MIN_ON_TIME;
      set_fade_div   = RST_FADE_DIVISOR;
      set_period     = RST_INTERVAL_PERIOD;
      set_blink_half = RST_BLINK_HALF_PERIOD;
      lamp_mode      = MODE_IDLE;
      lamp_lit       = 1'b0;
      lamp_bright    = DUTY_FULL;
      lamp_on_time   = RST_MIN_ON_TIME;
      lamp_ticks     = '0;
      lamp_intervals = '0;
      lamp_prescale  = '0;
      lamp_level     = '0;
      lamp_phase     = '0;
      lamp_blink_due = 1'b0;
      lamp_prev_tb   = 1'b1;
      lamp_prev_bb   = 1'b1;
      lamp_hold      = DUTY_OFF;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: fast timers so every phase of the lamp shows within a few items
      load_settings(8'd25, 8'd3, 8'd60, 8'd1, 16'd1, 16'd1, 16'd1);
      queue_item(REQ_RESTORE, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0);      // on-time below range
      queue_item(REQ_RESTORE, 1'b1, 1'b0, 1'b0, 8'd255, 8'd255);  // on-time above range
      queue_item(REQ_RESTORE, 1'b0, 1'b1, 1'b1, 8'd3, 8'd60);     // on-time at maximum
      queue_item(REQ_TICK, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0);         // first presses: wrap, floor
      queue_item(REQ_TICK, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0);         // held, no new press
      queue_item(REQ_TICK, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0);
      queue_item(REQ_TICK, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0);         // brightness 0 wraps to full
      queue_item(REQ_RESTORE, 1'b0, 1'b1, 1'b1, 8'd2, 8'd1);      // on-time at minimum
      queue_item(REQ_RESTORE, 1'b0, 1'b1, 1'b1, 8'd2, 8'd58);
      queue_item(REQ_TICK, 1'b0, 1'b0, 1'b1, 8'd0, 8'd0);         // reach max: blink from idle
      for (k = 0; k < 5; k++)
         queue_item(REQ_TICK, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0);
      queue_item(REQ_TICK, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255);     // motion: fade in
      queue_item(REQ_TICK, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0);
      queue_item(REQ_TICK, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0);
      queue_item(REQ_TICK, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0);         // motion while on
      queue_item(REQ_TICK, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0);         // always on at maximum
      queue_item(REQ_TICK, 1'b0, 1'b0, 1'b1, 8'd0, 8'd0);         // max wraps to min
      for (k = 0; k < 5; k++)
         queue_item(REQ_TICK, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0);     // fade out to idle
      queue_item(REQ_TICK, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0);
      wait_drained();

      // small on-time range, fast timers
      load_settings(8'd30, 8'd2, 8'd8, 8'd2, 16'd1, 16'd1, 16'd1);
      add_random_items(100);
      wait_drained();

      // upper extremes
      load_settings(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_random_items(30);
      wait_drained();

      // lower extremes
      load_settings(8'd1, 8'd1, 8'd1, 8'd0, 16'd1, 16'd1, 16'd1);
      add_random_items(60);
      wait_drained();

      // a stretch with both sides running flat out
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings(8'd100, 8'd3, 8'd10, 8'd1, 16'd2, 16'd3, 16'd2);
      add_random_items(100);
      wait_drained();
      send_idle_pct = 34;
      recv_idle_pct = 34;

      for (k = 0; k < 2; k++) begin
         load_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 6)),
                       8'($urandom_range(1, 12)), 8'($urandom_range(0, 13)),
                       16'($urandom_range(1, 3)), 16'($urandom_range(1, 4)),
                       16'($urandom_range(1, 3)));
         add_random_items(50);
         wait_drained();
      end

      // back to the power-on values
      load_settings(RST_BRIGHTNESS_STEP, RST_ON_TIME_STEP, RST_MAX_ON_TIME, RST_MIN_ON_TIME,
                    RST_FADE_DIVISOR, RST_INTERVAL_PERIOD, RST_BLINK_HALF_PERIOD);
      add_random_items(20);
      wait_drained();

      repeat (3) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

@@ files.f @@
sv/mldc_pkg.sv
sv/motion_led_dimmer_controller_top.sv
dv/motion_led_dimmer_controller_top_tb.sv
